// File: src/priority_task_ready_list_scheduler_assert.svh
// Assertion macros shared by the checker.
`ifndef PRIORITY_TASK_READY_LIST_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_READY_LIST_SCHEDULER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PTRLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequence is checked in the next clock cycle.
`define PTRLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: src/ptrls_pkg.sv
package ptrls_pkg;
   localparam int TaskSlots = 64;
   localparam int PriorityLevels = 16;
   localparam int WaitKinds = 2;
   localparam int SlotW = $clog2(TaskSlots);
   localparam int LinkW = SlotW + 1;
   localparam int LevelW = 4;
   localparam int KindW = 1;
   localparam int WaitW = 5;
   localparam int CountW = 7;
   localparam logic [LinkW-1:0] NilLink = LinkW'(TaskSlots);

   typedef enum logic [2:0] {
      OP_SPAWN = 3'd0, OP_YIELD = 3'd1, OP_WAKE = 3'd2,
      OP_PICK = 3'd3, OP_EXIT = 3'd4, OP_SETPRI = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_DONE = 3'd0, ST_PICKED = 3'd1, ST_IDLE = 3'd2,
      ST_ALL_EXITED = 3'd3, ST_WAKE_IGNORED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_STOP = 2'd0, MODE_READY = 2'd1, MODE_WAIT = 2'd2, MODE_CUR = 2'd3
   } mode_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [5:0] task_id;
      logic [3:0] priority_req;
      logic [0:0] wait_kind;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] picked_task;
      logic [6:0] live_tasks;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD1, S_RD2, S_WAKE_P, S_WAKE_N, S_PUSH,
      S_SCAN, S_XFER, S_XFER_RD, S_XFER_WR, S_POP_RD, S_POP_WR, S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic rd_slot;
      logic rd_aux;
      logic do_spawn;
      logic do_yield;
      logic wake_p;
      logic wake_n;
      logic do_push;
      logic scan_step;
      logic xfer_init;
      logic xfer_rd;
      logic xfer_wr;
      logic xfer_next;
      logic pop_rd;
      logic pop_wr;
      logic do_exit;
      logic do_setpri;
      logic finish;
      logic [2:0] status;
   } cmd_type;

   typedef struct packed {
      logic slot_ok;
      mode_type slot_mode;
      logic running_ok;
      logic total_zero;
      logic scan_found;
      logic scan_last;
      logic xfer_valid;
      logic xfer_last_level;
   } sts_type;

   function automatic logic [LevelW-1:0] clamp_level(input logic [3:0] v);
      return (32'(v) >= PriorityLevels) ? LevelW'(PriorityLevels - 1) : LevelW'(v);
   endfunction
endpackage

// File: src/ptrls_ram.sv
module ptrls_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: src/ptrls_ctrl.sv
module ptrls_ctrl
   import ptrls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic [2:0] opcode,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);
   state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic tried_ff, tried_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= '0;
         tried_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         tried_ff <= tried_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      tried_in = tried_ff;
      cmd = '0;
      cmd.status = ST_DONE;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               op_in = opcode;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            // Slot mode and link/level reads for the addressed task, or the current task for a yield.
            cmd.rd_slot = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_SPAWN: begin
                  if (sts.slot_ok && sts.slot_mode == MODE_STOP) begin
                     cmd.do_spawn = 1'b1;
                     state_in = S_PUSH;
                  end
               end
               OP_YIELD: begin
                  if (sts.running_ok) begin
                     cmd.do_yield = 1'b1;
                     state_in = S_PUSH;
                  end
               end
               OP_WAKE: begin
                  if (sts.slot_ok && sts.slot_mode == MODE_WAIT) begin
                     state_in = S_WAKE_P;
                  end else begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_WAKE_IGNORED;
                     state_in = S_IDLE;
                  end
               end
               OP_PICK: begin
                  if (sts.running_ok) begin
                     state_in = S_FINISH;
                  end else if (sts.total_zero) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_ALL_EXITED;
                     state_in = S_IDLE;
                  end else begin
                     tried_in = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               OP_EXIT: begin
                  cmd.do_exit = sts.running_ok;
               end
               OP_SETPRI: begin
                  cmd.do_setpri = sts.slot_ok;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_WAKE_P: begin
            cmd.wake_p = 1'b1;
            state_in = S_WAKE_N;
         end
         S_WAKE_N: begin
            cmd.wake_n = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd_aux = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            cmd.do_push = 1'b1;
            state_in = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_found) begin
               state_in = S_POP_RD;
            end else if (sts.scan_last) begin
               if (tried_ff) begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_IDLE;
                  state_in = S_IDLE;
               end else begin
                  tried_in = 1'b1;
                  cmd.xfer_init = 1'b1;
                  state_in = S_XFER;
               end
            end
         end
         S_XFER: begin
            if (sts.xfer_valid) begin
               cmd.xfer_rd = 1'b1;
               state_in = S_XFER_RD;
            end else begin
               cmd.xfer_next = 1'b1;
               if (sts.xfer_last_level) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_XFER_RD: begin
            // Hold the walk address so the links are still there next cycle.
            cmd.xfer_rd = 1'b1;
            state_in = S_XFER_WR;
         end
         S_XFER_WR: begin
            cmd.xfer_wr = 1'b1;
            state_in = S_XFER;
         end
         S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            cmd.pop_wr = 1'b1;
            cmd.finish = 1'b1;
            cmd.status = ST_PICKED;
            state_in = S_IDLE;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            cmd.status = ST_DONE;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// File: src/ptrls_datapath.sv
module ptrls_datapath
   import ptrls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   // Request registers.
   req_type req_ff;
   logic [LevelW-1:0] lvl_ff;

   // Small register state.
   logic [LinkW-1:0] ready_head_ff [PriorityLevels];
   logic [LinkW-1:0] wait_head_ff [PriorityLevels*WaitKinds];
   logic [LinkW-1:0] running_ff;
   logic [CountW-1:0] total_ff;

   // A slot's mode lives in memory; a slot never written since reset is stopped.
   logic [TaskSlots-1:0] md_vld_ff;

   // Working registers.
   logic [SlotW-1:0] tgt_ff;       // slot being pushed or unlinked
   logic [LinkW-1:0] p_ff, n_ff;   // its links
   logic [LevelW-1:0] tl_ff;       // its current level
   logic [WaitW-1:0] push_sel_ff;  // destination list: ready level or wait index
   logic push_wait_ff;
   logic [LevelW-1:0] scan_ff;
   logic [LevelW-1:0] xl_ff;
   logic [LinkW-1:0] xt_ff;
   logic [SlotW:0] guard_ff;
   logic [SlotW-1:0] pick_ff;

   // Link, level and mode memories.
   logic nl_we, pl_we, tl_we, pd_we, md_we;
   logic [SlotW-1:0] nl_wa, pl_wa, tl_wa, pd_wa, md_wa, rd_a;
   logic [LinkW-1:0] nl_wd, pl_wd, nl_rd, pl_rd;
   logic [LevelW-1:0] tl_wd, pd_wd, tl_rd, pd_rd;
   logic [1:0] md_wd, md_rd;

   ptrls_ram #(.Width(LinkW), .Depth(TaskSlots)) u_next (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_wa), .wr_data(nl_wd),
      .rd_addr(rd_a), .rd_data(nl_rd));
   ptrls_ram #(.Width(LevelW), .Depth(TaskSlots)) u_level (
      .clock(clock), .wr_en(tl_we), .wr_addr(tl_wa), .wr_data(tl_wd),
      .rd_addr(rd_a), .rd_data(tl_rd));
   ptrls_ram #(.Width(LevelW), .Depth(TaskSlots)) u_pend (
      .clock(clock), .wr_en(pd_we), .wr_addr(pd_wa), .wr_data(pd_wd),
      .rd_addr(rd_a), .rd_data(pd_rd));
   ptrls_ram #(.Width(2), .Depth(TaskSlots)) u_mode (
      .clock(clock), .wr_en(md_we), .wr_addr(md_wa), .wr_data(md_wd),
      .rd_addr(rd_a), .rd_data(md_rd));

   logic slot_ok;
   logic [SlotW-1:0] slot;
   logic [SlotW-1:0] run_slot;
   logic [LinkW-1:0] push_head;
   logic [WaitW-1:0] wk_idx;

   assign slot_ok = (32'(req_ff.task_id) < TaskSlots);
   assign slot = req_ff.task_id[SlotW-1:0];
   assign run_slot = running_ff[SlotW-1:0];
   assign push_head = push_wait_ff ? wait_head_ff[push_sel_ff]
                                   : ready_head_ff[push_sel_ff[LevelW-1:0]];
   assign wk_idx = WaitW'({tl_rd, 1'b0}) |
                   WaitW'((32'(req_ff.wait_kind) >= WaitKinds) ? WaitKinds - 1
                                                                : 32'(req_ff.wait_kind));

   // Read address follows the phase: target slot (running slot for a yield), transfer walk or pop head.
   always_comb begin
      rd_a = slot;
      if (cmd.rd_slot && req_ff.opcode == OP_YIELD) begin
         rd_a = run_slot;
      end else if (cmd.rd_aux) begin
         rd_a = tgt_ff;
      end else if (cmd.xfer_rd) begin
         rd_a = xt_ff[SlotW-1:0];
      end else if (cmd.pop_rd) begin
         rd_a = ready_head_ff[scan_ff][SlotW-1:0];
      end
   end

   assign sts.slot_ok = slot_ok;
   assign sts.slot_mode = md_vld_ff[slot] ? mode_type'(md_rd) : MODE_STOP;
   assign sts.running_ok = running_ff != NilLink;
   assign sts.total_zero = total_ff == '0;
   assign sts.scan_found = ready_head_ff[scan_ff] != NilLink;
   assign sts.scan_last = 32'(scan_ff) == PriorityLevels - 1;
   assign sts.xfer_valid = (xt_ff != NilLink) && (32'(guard_ff) < TaskSlots);
   assign sts.xfer_last_level = 32'(xl_ff) == PriorityLevels - 1;

   // Memory writes.
   always_comb begin
      nl_we = 1'b0; nl_wa = tgt_ff; nl_wd = push_head;
      pl_we = 1'b0; pl_wa = tgt_ff; pl_wd = NilLink;
      tl_we = 1'b0; tl_wa = slot; tl_wd = lvl_ff;
      pd_we = 1'b0; pd_wa = slot; pd_wd = lvl_ff;
      md_we = 1'b0; md_wa = slot; md_wd = MODE_READY;
      if (cmd.do_spawn) begin
         tl_we = 1'b1;
         pd_we = 1'b1;
         md_we = 1'b1;
      end
      if (cmd.do_yield) begin
         md_we = 1'b1; md_wa = run_slot; md_wd = MODE_WAIT;
      end
      if (cmd.do_setpri) begin
         pd_we = 1'b1;
      end
      if (cmd.wake_p && p_ff != NilLink) begin
         nl_we = 1'b1; nl_wa = p_ff[SlotW-1:0]; nl_wd = n_ff;
      end
      if (cmd.wake_n) begin
         md_we = 1'b1;
         if (n_ff != NilLink) begin
            pl_we = 1'b1; pl_wa = n_ff[SlotW-1:0]; pl_wd = p_ff;
         end
      end
      if (cmd.do_push) begin
         nl_we = 1'b1; nl_wa = tgt_ff; nl_wd = push_head;
         pl_we = 1'b1; pl_wa = tgt_ff; pl_wd = NilLink;
      end
      if (cmd.do_exit) begin
         md_we = 1'b1; md_wa = run_slot; md_wd = MODE_STOP;
      end
      if (cmd.xfer_wr) begin
         // Reverse the entry: links swap.
         nl_we = 1'b1; nl_wa = xt_ff[SlotW-1:0]; nl_wd = pl_rd;
         pl_we = 1'b1; pl_wa = xt_ff[SlotW-1:0]; pl_wd = nl_rd;
         md_we = 1'b1; md_wa = xt_ff[SlotW-1:0]; md_wd = MODE_READY;
      end
      if (cmd.pop_wr) begin
         tl_we = 1'b1; tl_wa = pick_ff; tl_wd = pd_rd;
         md_we = 1'b1; md_wa = pick_ff; md_wd = MODE_CUR;
         if (nl_rd != NilLink) begin
            pl_we = 1'b1; pl_wa = nl_rd[SlotW-1:0]; pl_wd = NilLink;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PriorityLevels; i++) begin
            ready_head_ff[i] <= NilLink;
         end
         for (int i = 0; i < PriorityLevels*WaitKinds; i++) begin
            wait_head_ff[i] <= NilLink;
         end
         md_vld_ff <= '0;
         running_ff <= NilLink;
         total_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (md_we) begin
            md_vld_ff[md_wa] <= 1'b1;
         end
         if (cmd.do_spawn) begin
            tgt_ff <= slot;
            push_wait_ff <= 1'b0;
            push_sel_ff <= WaitW'(lvl_ff);
            total_ff <= total_ff + 1'b1;
         end
         if (cmd.do_yield) begin
            tgt_ff <= run_slot;
            push_wait_ff <= 1'b1;
            push_sel_ff <= wk_idx;
            running_ff <= NilLink;
         end
         if (cmd.wake_p) begin
            if (p_ff == NilLink) begin
               // Head of a wait list: find which kind holds it.
               for (int k = WaitKinds - 1; k >= 0; k--) begin
                  if (wait_head_ff[WaitW'(32'(tl_ff)*WaitKinds + k)] == LinkW'(slot)) begin
                     wait_head_ff[WaitW'(32'(tl_ff)*WaitKinds + k)] <= n_ff;
                  end
               end
            end
         end
         if (cmd.wake_n) begin
            push_wait_ff <= 1'b0;
            push_sel_ff <= WaitW'(tl_ff);
            tgt_ff <= slot;
         end
         if (cmd.rd_slot) begin
            // Links and level become valid next cycle; capture in the decode state.
         end
         if (cmd.do_push) begin
            if (push_head != NilLink) begin
               // Previous link of the old head handled below.
            end
            if (push_wait_ff) begin
               wait_head_ff[push_sel_ff] <= LinkW'(tgt_ff);
            end else begin
               ready_head_ff[push_sel_ff[LevelW-1:0]] <= LinkW'(tgt_ff);
            end
         end
         if (cmd.do_exit) begin
            running_ff <= NilLink;
            if (total_ff != '0) begin
               total_ff <= total_ff - 1'b1;
            end
         end
         if (cmd.latch) begin
            req_ff <= req;
            lvl_ff <= clamp_level(req.priority_req);
            scan_ff <= '0;
         end
         if (cmd.scan_step && ready_head_ff[scan_ff] == NilLink && !sts.scan_last) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (cmd.xfer_init) begin
            scan_ff <= '0;
            xl_ff <= '0;
            xt_ff <= wait_head_ff[0];
            guard_ff <= '0;
         end
         if (cmd.xfer_wr) begin
            ready_head_ff[xl_ff] <= xt_ff;
            xt_ff <= nl_rd;
            guard_ff <= guard_ff + 1'b1;
         end
         if (cmd.xfer_next) begin
            wait_head_ff[WaitW'(32'(xl_ff)*WaitKinds)] <= NilLink;
            if (!sts.xfer_last_level) begin
               xl_ff <= xl_ff + 1'b1;
               xt_ff <= wait_head_ff[WaitW'((32'(xl_ff) + 1)*WaitKinds)];
            end
            guard_ff <= '0;
         end
         if (cmd.pop_rd) begin
            pick_ff <= ready_head_ff[scan_ff][SlotW-1:0];
         end
         if (cmd.pop_wr) begin
            ready_head_ff[scan_ff] <= nl_rd;
            running_ff <= LinkW'(pick_ff);
         end
         rsp_data.status <= cmd.status;
         rsp_data.picked_task <= (cmd.status == ST_PICKED) ? pick_ff : '0;
         rsp_data.live_tasks <= total_ff;
      end
   end

   // Capture links and level of the addressed slot in the cycle after the read.
   logic rd_slot_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_slot_d_ff <= 1'b0;
      end else begin
         rd_slot_d_ff <= cmd.rd_slot;
         if (rd_slot_d_ff) begin
            p_ff <= pl_rd;
            n_ff <= nl_rd;
            tl_ff <= tl_rd;
         end
      end
   end

   // The old head's previous link is written in the cycle after a push.
   logic fix_ff;
   logic [SlotW-1:0] fix_slot_ff, fix_val_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff <= 1'b0;
      end else begin
         fix_ff <= cmd.do_push && (push_head != NilLink);
         fix_slot_ff <= push_head[SlotW-1:0];
         fix_val_ff <= tgt_ff;
      end
   end

   // Second write port of prev_link is not available; the fixup shares the
   // finish cycle, where nothing else writes it.
   logic pfix_we;
   assign pfix_we = fix_ff;

   logic [LinkW-1:0] pl_fix_d;
   assign pl_fix_d = LinkW'(fix_val_ff);

   logic pl_we_m;
   logic [SlotW-1:0] pl_wa_m;
   logic [LinkW-1:0] pl_wd_m;
   assign pl_we_m = pl_we | pfix_we;
   assign pl_wa_m = pfix_we ? fix_slot_ff : pl_wa;
   assign pl_wd_m = pfix_we ? pl_fix_d : pl_wd;

   ptrls_ram #(.Width(LinkW), .Depth(TaskSlots)) u_prev (
      .clock(clock), .wr_en(pl_we_m), .wr_addr(pl_wa_m), .wr_data(pl_wd_m),
      .rd_addr(rd_a), .rd_data(pl_rd));
endmodule

// File: src/priority_task_ready_list_scheduler.sv
// Priority task ready-list scheduler.
// One command beat is taken at a rising edge where start is high and busy is
// low; it carries an opcode (spawn, yield, wake, pick, exit, set next
// priority), a task slot, a level and a wait kind. Each command gives exactly
// one response beat, marked by rsp_valid for a single cycle, with status,
// picked task and live count. A pick scans the ready heads one level per
// cycle until a level holds a task. With nothing ready it walks the
// plain-yield lists, moving each task back through a read, a held read and a
// write of its links over the single link read port, and scans again; it
// answers idle when that still finds nothing. A new beat is accepted in the
// response cycle, so commands are handled one at a time.
// Reset clears all ready and wait heads, the per-slot written flags (so every
// slot reads as stopped), the current task and the live count.
// The receiver cannot stall: each response must be taken in its one cycle.
module priority_task_ready_list_scheduler
   import ptrls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   // The controller sequences each command; the datapath holds the lists, slots and counts.
   ptrls_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .opcode(req_data.opcode),
      .sts(sts), .cmd(cmd), .busy(busy));

   ptrls_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data));
endmodule

// File: src/ptrls_checker.sv
`include "priority_task_ready_list_scheduler_assert.svh"
module ptrls_checker
   import ptrls_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input rsp_type rsp_data,
   input logic    rsp_valid
);
   `PTRLS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `PTRLS_ASSERT_IMP(a_pick_only, clock, reset, rsp_valid && rsp_data.status != ST_PICKED, rsp_data.picked_task == '0, "picked task without pick")
   `PTRLS_ASSERT_IMP(a_live_max, clock, reset, rsp_valid, rsp_data.live_tasks <= 7'd64, "live count overflow")
   `PTRLS_ASSERT_NEXT(a_single, clock, reset, rsp_valid, !rsp_valid, "response repeated")
endmodule

bind priority_task_ready_list_scheduler ptrls_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_data(rsp_data), .rsp_valid(rsp_valid));

// File: tb/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the priority task ready-list scheduler.
// Every command beat that the block accepts is also run through a local
// model of the slot table and its ready and wait lists. The model's response
// joins a queue, and each response beat is compared with the oldest entry.
module tb_top;
   import ptrls_pkg::*;

   // Opcodes that the block must treat as no-ops.
   localparam logic [2:0] OpUnused6 = 3'd6;
   localparam logic [2:0] OpUnused7 = 3'd7;
   localparam int CycleLimit = 2000000;
   localparam int EndSettle = 300;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   priority_task_ready_list_scheduler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Outputs change just after the rising edge. They are sampled on the
   // falling edge, so nothing here depends on the order of events at an edge.
   logic busy_seen;
   always @(negedge clock) busy_seen <= busy;

   // Model state: slot table, list links and list heads.
   logic [LinkW-1:0]  slot_next [TaskSlots];
   logic [LinkW-1:0]  slot_prev [TaskSlots];
   mode_type          slot_mode [TaskSlots];
   logic [LevelW-1:0] slot_level [TaskSlots];
   logic [LevelW-1:0] slot_pending [TaskSlots];
   logic [LinkW-1:0]  ready_top [PriorityLevels];
   logic [LinkW-1:0]  wait_top [PriorityLevels*WaitKinds];
   logic [LinkW-1:0]  current_slot;
   int                live_count;

   rsp_type expected_rsp[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      idle_pct = 0;

   function automatic void clear_lists();
      for (int i = 0; i < TaskSlots; i++) begin
         slot_next[i] = NilLink;
         slot_prev[i] = NilLink;
         slot_mode[i] = MODE_STOP;
         slot_level[i] = '0;
         slot_pending[i] = '0;
      end
      for (int i = 0; i < PriorityLevels; i++) ready_top[i] = NilLink;
      for (int i = 0; i < PriorityLevels*WaitKinds; i++) wait_top[i] = NilLink;
      current_slot = NilLink;
      live_count = 0;
   endfunction

   // Links slot t in front of the list whose head is given; returns the new head.
   function automatic logic [LinkW-1:0] push_slot(input logic [LinkW-1:0] head,
                                                  input int t);
      slot_prev[t] = NilLink;
      slot_next[t] = head;
      if (head != NilLink) slot_prev[head[SlotW-1:0]] = LinkW'(t);
      return LinkW'(t);
   endfunction

   function automatic int top_ready_level();
      for (int i = 0; i < PriorityLevels; i++)
         if (ready_top[i] != NilLink) return i;
      return -1;
   endfunction

   // Plain-yield lists go back to their ready lists reversed, so the task that
   // yielded first ends up at the head.
   function automatic void requeue_yielded();
      logic [LinkW-1:0] t, older;
      int guard;
      for (int i = 0; i < PriorityLevels; i++) begin
         t = wait_top[i*WaitKinds];
         guard = 0;
         while (t != NilLink && guard < TaskSlots) begin
            older = slot_next[t];
            slot_next[t] = slot_prev[t];
            slot_prev[t] = older;
            slot_mode[t] = MODE_READY;
            ready_top[i] = t;
            t = older;
            guard++;
         end
         wait_top[i*WaitKinds] = NilLink;
      end
   endfunction

   function automatic rsp_type schedule_command(req_type r);
      rsp_type res;
      logic [LevelW-1:0] lv;
      logic [LinkW-1:0] p, n, c;
      int t, l, w;
      res = '0;
      lv = (int'(r.priority_req) >= PriorityLevels) ? LevelW'(PriorityLevels - 1)
                                                    : r.priority_req;
      t = int'(r.task_id);
      w = (int'(r.wait_kind) >= WaitKinds) ? WaitKinds - 1 : int'(r.wait_kind);
      res.status = ST_DONE;
      case (r.opcode)
         OP_SPAWN: begin
            if (t < TaskSlots && slot_mode[t] == MODE_STOP) begin
               slot_level[t] = lv;
               slot_pending[t] = lv;
               ready_top[lv] = push_slot(ready_top[lv], t);
               slot_mode[t] = MODE_READY;
               live_count++;
            end
         end
         OP_YIELD: begin
            if (current_slot != NilLink) begin
               c = current_slot;
               l = slot_level[c]*WaitKinds + w;
               wait_top[l] = push_slot(wait_top[l], int'(c));
               slot_mode[c] = MODE_WAIT;
               current_slot = NilLink;
            end
         end
         OP_WAKE: begin
            if (t < TaskSlots && slot_mode[t] == MODE_WAIT) begin
               l = slot_level[t];
               p = slot_prev[t];
               n = slot_next[t];
               if (p != NilLink) slot_next[p] = n;
               else begin
                  for (int k = 0; k < WaitKinds; k++)
                     if (wait_top[l*WaitKinds + k] == LinkW'(t)) begin
                        wait_top[l*WaitKinds + k] = n;
                        break;
                     end
               end
               if (n != NilLink) slot_prev[n] = p;
               ready_top[l] = push_slot(ready_top[l], t);
               slot_mode[t] = MODE_READY;
            end else res.status = ST_WAKE_IGNORED;
         end
         OP_PICK: begin
            if (current_slot != NilLink) begin
               res.status = ST_DONE;
            end else if (live_count == 0) begin
               res.status = ST_ALL_EXITED;
            end else begin
               l = top_ready_level();
               if (l < 0) begin
                  requeue_yielded();
                  l = top_ready_level();
               end
               if (l < 0) res.status = ST_IDLE;
               else begin
                  c = ready_top[l];
                  n = slot_next[c];
                  ready_top[l] = n;
                  if (n != NilLink) slot_prev[n] = NilLink;
                  slot_mode[c] = MODE_CUR;
                  slot_level[c] = slot_pending[c];
                  current_slot = c;
                  res.status = ST_PICKED;
                  res.picked_task = c[SlotW-1:0];
               end
            end
         end
         OP_EXIT: begin
            if (current_slot != NilLink) begin
               slot_mode[current_slot] = MODE_STOP;
               current_slot = NilLink;
               if (live_count > 0) live_count--;
            end
         end
         OP_SETPRI: begin
            if (t < TaskSlots) slot_pending[t] = lv;
         end
         default: ;
      endcase
      res.live_tasks = 7'(live_count);
      return res;
   endfunction

   // Sends one command beat. Before raising start the sender idles in each
   // cycle with the chance idle_pct; start stays high after acceptance when no
   // idle cycle follows, so back-to-back beats never lower and raise start in
   // one step.
   task automatic send_command(input logic [2:0] op, input int id, input int pri,
                               input int kind);
      req_type r;
      r.opcode = op;
      r.task_id = 6'(id);
      r.priority_req = 4'(pri);
      r.wait_kind = 1'(kind);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy_seen);
      expected_rsp.push_back(schedule_command(r));
   endtask

   // Holds the sender off until every expected response has arrived.
   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0 || busy_seen);
   endtask

   // Response check. The receiver cannot stall, so every strobed beat is taken.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
            if (rsp_data.picked_task !== want.picked_task)
               $display("%0t: picked_task expected %0d actual %0d", $time,
                        want.picked_task, rsp_data.picked_task);
            if (rsp_data.live_tasks !== want.live_tasks)
               $display("%0t: live_tasks expected %0d actual %0d", $time,
                        want.live_tasks, rsp_data.live_tasks);
            if (rsp_data !== want) error_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Directed checks of each operation and each corner that the scheduler
   // is meant to handle.
   task automatic test_directed();
      idle_pct = 0;
      send_command(OP_PICK, 0, 0, 0);        // nothing live: all exited
      send_command(OP_YIELD, 0, 0, 1);       // no current task
      send_command(OP_EXIT, 0, 0, 0);        // no current task
      send_command(OP_SPAWN, 63, 15, 0);
      send_command(OP_SPAWN, 0, 0, 0);
      send_command(OP_SPAWN, 0, 9, 0);       // live slot, ignored
      send_command(OP_SPAWN, 42, 0, 0);
      send_command(OP_WAKE, 42, 0, 0);       // ready task: wake ignored
      send_command(OP_SETPRI, 0, 15, 1);
      send_command(OP_PICK, 0, 0, 0);        // newest at level 0 first
      send_command(OP_PICK, 0, 0, 0);        // already current: ignored
      send_command(OP_YIELD, 0, 0, 0);
      send_command(OP_PICK, 0, 0, 0);
      send_command(OP_YIELD, 0, 0, 1);       // waits for I/O
      send_command(OP_PICK, 0, 0, 0);
      send_command(OP_YIELD, 0, 0, 0);
      send_command(OP_PICK, 0, 0, 0);        // nothing ready: yields go back
      send_command(OP_EXIT, 0, 0, 0);
      send_command(OP_PICK, 0, 0, 0);
      send_command(OP_YIELD, 0, 0, 1);
      send_command(OP_PICK, 0, 0, 0);        // only I/O waiters: idle
      send_command(OpUnused6, 63, 15, 1);
      send_command(OpUnused7, 21, 5, 0);
      send_command(OP_WAKE, 0, 0, 0);
      send_command(OP_WAKE, 63, 0, 0);
      drain_responses();
   endtask

   // Mostly well-formed traffic on a small pool of slots so that the lists
   // get deep, with the full slot range mixed in.
   task automatic test_random(input int count, input int pct);
      int w, op, id;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         w = $urandom_range(99);
         if (w < 18) op = OP_SPAWN;
         else if (w < 36) op = OP_YIELD;
         else if (w < 52) op = OP_WAKE;
         else if (w < 80) op = OP_PICK;
         else if (w < 89) op = OP_EXIT;
         else if (w < 97) op = OP_SETPRI;
         else op = $urandom_range(1) ? OpUnused6 : OpUnused7;
         id = $urandom_range(1) ? $urandom_range(0, 11) : $urandom_range(0, 63);
         send_command(3'(op), id, $urandom_range(0, 15), $urandom_range(0, 1));
         if ($urandom_range(99) == 0) drain_responses();
      end
      drain_responses();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      clear_lists();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(480, 0);
      test_random(480, 71);
      test_random(480, 11);
      test_random(480, 0);
      repeat (EndSettle) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
